/* sv/transitive_closure_reachability_assert.svh */
// Assertion macros shared by the transitive closure reachability RTL.
`ifndef TRANSITIVE_CLOSURE_REACHABILITY_ASSERT_SVH
`define TRANSITIVE_CLOSURE_REACHABILITY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tcr_pkg.sv */
// Package with the constants, codes and types of the transitive closure reachability block.
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

	localparam int MAX_NODES = 128;
	localparam int NODE_W    = 7;
	localparam int CFG_W     = 8;
	localparam int OP_W      = 2;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);

	localparam logic [CFG_W-1:0] CC_RESET = CFG_W'(128);

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

	typedef logic [MAX_NODES-1:0] row_t;

	typedef struct packed {
		logic clear;
		logic start;
		logic step;
		logic wr;
		logic qry;
	} tcr_ctl_t;

endpackage

`default_nettype wire

/* sv/tcr_if.sv */
// Handshake interfaces for the item, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface tcr_item_if import tcr_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [NODE_W-1:0] source_node;
	logic [NODE_W-1:0] target_node;

	modport source (output valid, output operation, output source_node,
		output target_node, input ready);
	modport sink (input valid, input operation, input source_node,
		input target_node, output ready);
endinterface

interface tcr_res_if;
	logic valid;
	logic ready;
	logic reachable;
	logic out_of_range;

	modport source (output valid, output reachable, output out_of_range, input ready);
	modport sink (input valid, input reachable, input out_of_range, output ready);
endinterface

interface tcr_cfg_if import tcr_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/transitive_closure_reachability.sv */
// Top level of the transitive closure reachability block: control, ring of row cells, result register.
//
//   channel  dir  beat payload
//   item     in   operation, source_node, target_node
//   result   out  reachable, out_of_range
//   cfg      in   data (course_count)
//
// Clear, add edge and out-of-range items give their result in the cycle after the beat is taken;
// for a query, each cell first registers its own hit, and the OR over all cells is then registered.
// Close rotates the row ring once, one pivot row per cycle.
// Reset clears the whole matrix at once; no clearing pass is needed.
// The result register holds a stalled result; a new item is taken while it drains.
`timescale 1ns / 1ps
`default_nettype none

module transitive_closure_reachability import tcr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	tcr_item_if.sink  item,
	tcr_res_if.source result,
	tcr_cfg_if.sink   cfg
);

	`include "transitive_closure_reachability_assert.svh"

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLOSE = 2'd1;
	localparam logic [1:0] ST_QRY   = 2'd2;

	localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(MAX_NODES - 1);
	localparam int               CMP_W     = CNT_W + NODE_W;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] cc_q;
	logic [IDX_W-1:0] step_cnt_q;
	row_t             khot_q;
	row_t             colmask_q;
	row_t             colmask_d;
	row_t             src_hot;
	row_t             dst_hot;
	logic             out_valid_q;
	logic             reach_q;
	logic             oor_q;

	logic [CNT_W-1:0] n_nodes;
	logic             accept;
	logic             node_op;
	logic             oor;
	tcr_ctl_t         ctl;

	row_t             rows   [MAX_NODES];
	logic [MAX_NODES-1:0] acts;
	logic [MAX_NODES-1:0] hits;

	assign n_nodes = ({1'b0, cc_q} > (CFG_W + 1)'(MAX_NODES)) ? CNT_W'(MAX_NODES)
		: CNT_W'(cc_q);

	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign accept     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	always_comb begin
		node_op = (item.operation == OP_ADD) || (item.operation == OP_QUERY);
		oor = node_op && ((CMP_W'(item.source_node) >= CMP_W'(n_nodes))
			|| (CMP_W'(item.target_node) >= CMP_W'(n_nodes)));
		ctl.clear = accept && (item.operation == OP_CLEAR);
		ctl.start = accept && (item.operation == OP_CLOSE);
		ctl.step  = (state_q == ST_CLOSE);
		ctl.wr    = accept && (item.operation == OP_ADD) && !oor;
		ctl.qry   = accept && (item.operation == OP_QUERY) && !oor;
	end

	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) begin
			colmask_d[j] = (CNT_W'(j) < n_nodes);
			src_hot[j]   = (int'(item.source_node) == j);
			dst_hot[j]   = (int'(item.target_node) == j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CC_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cc_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_cnt_q <= '0;
					if (ctl.start) begin
						state_q <= ST_CLOSE;
					end else if (ctl.qry) begin
						state_q <= ST_QRY;
					end
				end
				ST_CLOSE: begin
					step_cnt_q <= step_cnt_q + 1'b1;
					if (step_cnt_q == STEP_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QRY: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			khot_q    <= row_t'(1);
			colmask_q <= colmask_d;
		end else if (ctl.step) begin
			khot_q <= {khot_q[MAX_NODES-2:0], khot_q[MAX_NODES-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !ctl.qry) || (state_q == ST_QRY)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !ctl.qry) begin
			reach_q <= 1'b0;
			oor_q   <= oor;
		end else if (state_q == ST_QRY) begin
			reach_q <= |hits;
			oor_q   <= 1'b0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.reachable    = reach_q;
	assign result.out_of_range = oor_q;

	for (genvar p = 0; p < MAX_NODES; p++) begin : g_cell
		tcr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sel       (src_hot[p]),
			.use_row   (colmask_d[p]),
			.dst_hot   (dst_hot),
			.nbr_row   (rows[(p + 1) % MAX_NODES]),
			.nbr_act   (acts[(p + 1) % MAX_NODES]),
			.pivot_row (rows[0]),
			.pivot_act (acts[0]),
			.khot      (khot_q),
			.colmask   (colmask_q),
			.row       (rows[p]),
			.act       (acts[p]),
			.hit       (hits[p])
		);
	end

	`TCR_ASSERT_NEXT(a_qry_enter, ctl.qry, state_q == ST_QRY, "Accepted query did not start lookup.")
	`TCR_ASSERT_NEXT(a_qry_result, state_q == ST_QRY, out_valid_q, "Query lookup gave no result.")
	`TCR_ASSERT_SAME(a_khot_onehot, state_q == ST_CLOSE, $onehot(khot_q), "Pivot select not one-hot.")
	`TCR_ASSERT_NEXT(a_close_done, (state_q == ST_CLOSE) && (step_cnt_q == STEP_LAST), state_q == ST_IDLE, "Closure did not end after one ring rotation.")
	`TCR_ASSERT_SAME(a_no_overrun, accept, !out_valid_q || result.ready, "Item taken while the result register was full.")

endmodule

`default_nettype wire

/* sv/tcr_cell.sv */
// One cell of the ring: holds one adjacency row and applies closure steps to its neighbor's row.
`timescale 1ns / 1ps
`default_nettype none

module tcr_cell import tcr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire tcr_ctl_t ctl,
	input  wire logic     sel,
	input  wire logic     use_row,
	input  wire row_t     dst_hot,
	input  wire row_t     nbr_row,
	input  wire logic     nbr_act,
	input  wire row_t     pivot_row,
	input  wire logic     pivot_act,
	input  wire row_t     khot,
	input  wire row_t     colmask,
	output row_t          row,
	output logic          act,
	output logic          hit
);

	row_t row_q;
	logic act_q;
	logic hit_q;
	logic takes_pivot;
	row_t step_row;

	always_comb begin
		takes_pivot = nbr_act && pivot_act && (|(nbr_row & khot));
		step_row    = nbr_row | (takes_pivot ? (pivot_row & colmask) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			act_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				row_q <= '0;
			end else if (ctl.step) begin
				row_q <= step_row;
			end else if (ctl.wr && sel) begin
				row_q <= row_q | dst_hot;
			end
			if (ctl.start) begin
				act_q <= use_row;
			end else if (ctl.step) begin
				act_q <= nbr_act;
			end
			hit_q <= ctl.qry && sel && (|(row_q & dst_hot));
		end
	end

	assign row = row_q;
	assign act = act_q;
	assign hit = hit_q;

endmodule

`default_nettype wire
